// ===== src/vrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

	localparam int STEP_CAP_DEF      = 64;
	localparam int FRACTION_BITS_DEF = 16;

	// quotients (crossing times before stepping) never exceed 2^16
	localparam int QUO_W  = 17;
	// crossing time with an extra bit for "infinite"
	localparam int TIME_W = 33;
	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] TIME_INF = {1'b1, {(TIME_W-1){1'b0}}};

	localparam int IN_W  = 152;
	localparam int OUT_W = 56;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/vrt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, quotient known below 2^QW.
// ----------------------------------------------------------------------------
module vrt_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output vrt_pkg::div_rsp_t    rsp
);
	localparam int QW  = vrt_pkg::QUO_W;
	localparam int CW  = $clog2(QW + 1);

	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    low_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   cand;
	logic             fit;

	assign cand = {rem_q, low_q[QW-1]};
	assign fit  = cand >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high part of the numerator is always below the divisor by construction
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= DEN_W'(num[NUM_W-1:QW]);
			low_q <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			if (fit) rem_q <= DEN_W'(cand - {1'b0, den_q});
			else     rem_q <= cand[DEN_W-1:0];
			low_q <= {low_q[QW-2:0], fit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = low_q;
endmodule

// ===== src/voxel_ray_traversal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// 3D fixed-point voxel walk of a ray, one voxel per result item.
// ----------------------------------------------------------------------------
// Usage: a ray item (start point, heading, step limit) enters on the s_axis
// channel. The block then emits on m_axis one item per voxel the ray enters,
// up to min(step_limit, STEP_CAP) items; tlast marks the last one. Rays with
// an all-zero heading or a zero limit give no items.
// Timing: after acceptance the shared divider runs six divisions (three
// boundary crossing times, three per-voxel deltas) one after another, each
// with a start, 17 quotient bits and a hand-back. The walk then gives one
// voxel per cycle while the receiver takes items.
// s_axis_tready is high only while no ray is in flight; the last result may
// still sit in the output register while the next ray is taken.
// When the receiver holds m_axis_tready low the walk freezes with the
// pending item held in the output register; nothing is dropped.
// Reset (arst_n low) clears the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
module voxel_ray_traversal #(
	parameter int STEP_CAP      = vrt_pkg::STEP_CAP_DEF,
	parameter int FRACTION_BITS = vrt_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// start_x[31:0] start_y[63:32] start_z[95:64] heading_x[111:96]
	// heading_y[127:112] heading_z[143:128] step_limit[150:144]
	input  logic [vrt_pkg::IN_W-1:0] s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// voxel_x[15:0] voxel_y[31:16] voxel_z[47:32] step_number[53:48]
	output logic [vrt_pkg::OUT_W-1:0] m_axis_tdata,
	output logic                     m_axis_tlast
);
	localparam int F     = FRACTION_BITS;
	localparam int NUM_W = F + 17;
	localparam int DEN_W = F + 16;
	localparam int TW    = vrt_pkg::TIME_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [1:0]   state_q;
	logic [2:0]   div_idx_q;
	logic         pend_q;
	logic [6:0]   cnt_q;
	logic [6:0]   lim_q;

	logic [F-1:0]  frac_q [3];
	logic [15:0]   mag_q  [3];
	logic          neg_q  [3];
	logic          zero_q [3];
	logic [15:0]   vox_q  [3];
	logic [TW-1:0] tim_q  [3];
	logic [TW-1:0] del_q  [3];

	logic          out_v_q;
	logic [15:0]   ovx_q, ovy_q, ovz_q;
	logic [5:0]    ostep_q;
	logic          olast_q;

	// input unpacking
	logic [31:0] pos_in [3];
	logic [15:0] hd_in  [3];
	logic [6:0]  lim_in;
	assign pos_in[0] = s_axis_tdata[31:0];
	assign pos_in[1] = s_axis_tdata[63:32];
	assign pos_in[2] = s_axis_tdata[95:64];
	assign hd_in[0]  = s_axis_tdata[111:96];
	assign hd_in[1]  = s_axis_tdata[127:112];
	assign hd_in[2]  = s_axis_tdata[143:128];
	assign lim_in    = s_axis_tdata[150:144];

	logic [6:0] n_in;
	logic       all_zero;
	assign n_in     = (lim_in > 7'(STEP_CAP)) ? 7'(STEP_CAP) : lim_in;
	assign all_zero = (hd_in[0] == '0) && (hd_in[1] == '0) && (hd_in[2] == '0);

	// divider operands: even index = first crossing time, odd = delta
	logic [1:0]       ax_sel;
	logic [F:0]       span;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;
	vrt_pkg::div_rsp_t rsp;
	logic             div_go;

	assign ax_sel = div_idx_q[2:1];
	always_comb begin
		span = neg_q[ax_sel] ? {1'b0, frac_q[ax_sel]}
		                     : (F+1)'((F+1)'(1) << F) - {1'b0, frac_q[ax_sel]};
		num  = div_idx_q[0] ? {1'b1, {(NUM_W-1){1'b0}}} : {span, 16'b0};
		den  = {mag_q[ax_sel], {F{1'b0}}};
	end
	assign div_go = (state_q == ST_DIV) && !pend_q;

	vrt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(num), .den(den), .rsp(rsp)
	);

	// walk: pick axis (ties go to the later axis, z over y over x), step it
	logic [1:0]    ax;
	logic          adv;
	logic [TW-1:0] sum;
	always_comb begin
		if (tim_q[0] < tim_q[1]) ax = (tim_q[0] < tim_q[2]) ? 2'd0 : 2'd2;
		else                     ax = (tim_q[1] < tim_q[2]) ? 2'd1 : 2'd2;
		sum = tim_q[ax] + del_q[ax];
		if (sum > vrt_pkg::TIME_MAX) sum = vrt_pkg::TIME_MAX;
	end
	assign adv = (state_q == ST_WALK) && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_idx_q <= '0;
			pend_q    <= 1'b0;
			cnt_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (adv) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && !all_zero && n_in != '0) begin
						state_q   <= ST_DIV;
						div_idx_q <= '0;
						pend_q    <= 1'b0;
						cnt_q     <= '0;
					end
				end
				ST_DIV: begin
					if (div_go) pend_q <= 1'b1;
					if (rsp.done) begin
						pend_q <= 1'b0;
						if (div_idx_q == 3'd5) state_q <= ST_WALK;
						else div_idx_q <= div_idx_q + 3'd1;
					end
				end
				ST_WALK: begin
					if (adv) begin
						cnt_q   <= cnt_q + 7'd1;
						if (cnt_q + 7'd1 == lim_q) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lim_q <= n_in;
			for (int a = 0; a < 3; a++) begin
				frac_q[a] <= pos_in[a][F-1:0];
				neg_q[a]  <= hd_in[a][15];
				zero_q[a] <= (hd_in[a] == '0);
				mag_q[a]  <= hd_in[a][15] ? 16'(-hd_in[a]) : hd_in[a];
				vox_q[a]  <= 16'($signed(pos_in[a]) >>> F);
			end
		end
		if (state_q == ST_DIV && rsp.done) begin
			if (zero_q[ax_sel]) begin
				if (!div_idx_q[0]) tim_q[ax_sel] <= vrt_pkg::TIME_INF;
				else               del_q[ax_sel] <= '0;
			end else if (!div_idx_q[0]) tim_q[ax_sel] <= TW'(rsp.quo);
			else                        del_q[ax_sel] <= TW'(rsp.quo);
		end
		if (adv) begin
			logic [15:0] nv;
			nv = neg_q[ax] ? vox_q[ax] - 16'd1 : vox_q[ax] + 16'd1;
			vox_q[ax] <= nv;
			tim_q[ax] <= sum;
			ovx_q   <= (ax == 2'd0) ? nv : vox_q[0];
			ovy_q   <= (ax == 2'd1) ? nv : vox_q[1];
			ovz_q   <= (ax == 2'd2) ? nv : vox_q[2];
			ostep_q <= cnt_q[5:0];
			olast_q <= (cnt_q + 7'd1 == lim_q);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b0, ostep_q, ovz_q, ovy_q, ovx_q};
	assign m_axis_tlast  = olast_q;
endmodule

// ===== test/voxel_ray_traversal_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_test
// Self-checking bench for the voxel ray walk: rays go in on s_axis, each
// voxel item coming out on m_axis is compared with a built-in fixed-point
// walk of the same ray. Random stalls on both sides, three idling phases.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_test;

	localparam int CAP   = 64;
	localparam int FRAC  = 16;
	localparam logic [32:0] T_MAX = 33'h0_FFFF_FFFF;
	localparam logic [32:0] T_INF = 33'h1_0000_0000;
	localparam int N_RAND = 410;

	typedef struct packed {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] vz;
		logic [5:0]  num;
		logic        last;
	} voxel_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [vrt_pkg::IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [vrt_pkg::OUT_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	logic [vrt_pkg::IN_W-1:0] ray_queue[$];
	voxel_t voxels_due[$];
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_send;
	bit in_taken;
	int n_bad;
	int n_voxels;
	int n_rays;

	voxel_ray_traversal u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// per-axis setup: start voxel, first crossing time, delta, step direction
	function automatic void setup_axis(input logic [31:0] pos, input logic [15:0] h,
			output logic [15:0] vox, output logic [32:0] tmax,
			output logic [32:0] tdelta, output logic [15:0] stepv);
		logic [63:0] mag;
		logic [63:0] span;
		logic [63:0] t;
		logic [63:0] frac;
		vox = pos[31:16];	// arithmetic floor by Q16.16 is just the top half
		frac = {48'd0, pos[FRAC-1:0]};
		if (h == 16'd0) begin
			tmax = T_INF;
			tdelta = '0;
			stepv = '0;
			return;
		end
		if (h[15]) begin
			mag = 64'h10000 - {48'd0, h};
			span = frac;
			stepv = 16'hFFFF;
		end else begin
			mag = {48'd0, h};
			span = (64'd1 << FRAC) - frac;
			stepv = 16'd1;
		end
		t = (span << 16) / (mag << FRAC);
		tmax = (t > {31'd0, T_MAX}) ? T_MAX : t[32:0];
		tdelta = 33'(64'h10000 / mag);
	endfunction

	// walk one ray and queue the voxel items it should produce
	task automatic walk_ray(input logic [vrt_pkg::IN_W-1:0] ray);
		logic [15:0] vox[3];
		logic [32:0] tm[3];
		logic [32:0] td[3];
		logic [15:0] sv[3];
		logic [33:0] s;
		int n;
		int ax;
		voxel_t v;
		for (int a = 0; a < 3; a++)
			setup_axis(ray[32*a +: 32], ray[96 + 16*a +: 16], vox[a], tm[a], td[a], sv[a]);
		if (sv[0] == 0 && sv[1] == 0 && sv[2] == 0)
			return;
		n = ray[150:144];
		if (n > CAP)
			n = CAP;
		for (int k = 0; k < n; k++) begin
			// ties go to the later axis: z over y over x
			if (tm[0] < tm[1])
				ax = (tm[0] < tm[2]) ? 0 : 2;
			else
				ax = (tm[1] < tm[2]) ? 1 : 2;
			vox[ax] = vox[ax] + sv[ax];
			s = {1'b0, tm[ax]} + {1'b0, td[ax]};
			tm[ax] = (s > {1'b0, T_MAX}) ? T_MAX : s[32:0];
			v.vx = vox[0];
			v.vy = vox[1];
			v.vz = vox[2];
			v.num = 6'(k);
			v.last = (k + 1 == n);
			voxels_due.push_back(v);
		end
	endtask

	function automatic logic [vrt_pkg::IN_W-1:0] pack_ray(input logic [31:0] px, py, pz,
			input logic [15:0] hx, hy, hz, input logic [6:0] lim);
		return {1'b0, lim, hz, hy, hx, pz, py, px};
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return {16'($urandom_range(0, 7) - 4), 16'($urandom())};
			2: return {16'($urandom()), 16'd0};	// on a boundary
			default: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
		endcase
	endfunction

	function automatic logic [15:0] rand_head();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'($urandom_range(1, 4));
			2: return -16'($urandom_range(1, 4));
			3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [6:0] rand_limit();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'($urandom_range(65, 127));
			2: return 7'd64;
			default: return 7'($urandom_range(1, 12));
		endcase
	endfunction

	// input side: note each accepted ray and predict its voxel items
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			walk_ray(s_axis_tdata);
			n_rays++;
		end
	end

	// driver: offers rays from the queue at falling edges
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_taken || !arst_n) begin
			if (arst_n && !hold_send && ray_queue.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= ray_queue.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: checks each voxel item against the oldest prediction
	always @(posedge clk) begin
		voxel_t want;
		voxel_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.vx = m_axis_tdata[15:0];
			got.vy = m_axis_tdata[31:16];
			got.vz = m_axis_tdata[47:32];
			got.num = m_axis_tdata[53:48];
			got.last = m_axis_tlast;
			n_voxels++;
			if (voxels_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected voxel item %h last %b", m_axis_tdata, m_axis_tlast);
			end else begin
				want = voxels_due.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display({"voxel mismatch: exp x %h y %h z %h n %0d last %b, ",
							"got x %h y %h z %h n %0d last %b"},
							want.vx, want.vy, want.vz, want.num, want.last,
							got.vx, got.vy, got.vz, got.num, got.last);
				end
			end
		end
	end

	task automatic wait_drained();
		while (ray_queue.size() != 0 || s_axis_tvalid || voxels_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			ray_queue.push_back(pack_ray(rand_pos(), rand_pos(), rand_pos(),
				rand_head(), rand_head(), rand_head(), rand_limit()));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		hold_send = 1'b0;
		n_bad = 0;
		n_voxels = 0;
		n_rays = 0;
		send_idle_pct = 8;
		recv_idle_pct = 56;
		// directed rays: axis-aligned, ties, boundaries, extremes, zero cases
		ray_queue.push_back(pack_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
			16'd1, 16'd0, 16'd0, 7'd4));
		ray_queue.push_back(pack_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
			16'd1, 16'd1, 16'd1, 7'd9));	// three-way tie
		ray_queue.push_back(pack_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
			16'd1, 16'd1, 16'd0, 7'd6));	// x/y tie
		ray_queue.push_back(pack_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'hFFFF,
			16'd1, 16'h8000, 7'd8));	// on boundaries, negative headings
		ray_queue.push_back(pack_ray(32'h0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 7'd10));
		ray_queue.push_back(pack_ray(32'h1234_5678, 32'h0, 32'h0, 16'd3, 16'd2, 16'd1, 7'd0));
		ray_queue.push_back(pack_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			16'h7FFF, 16'h8000, 16'h7FFF, 7'd64));	// coordinate wrap
		ray_queue.push_back(pack_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
			16'h8001, 16'h0001, 16'hFFFF, 7'd127));	// limit saturates
		ray_queue.push_back(pack_ray(32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF,
			16'd1, 16'hFFFF, 16'h7FFF, 7'd65));
		ray_queue.push_back(pack_ray(32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_F0F0,
			16'h5555, 16'hAAAA, 16'h00FF, 7'd1));
		ray_queue.push_back(pack_ray(32'h0, 32'h0, 32'h0, 16'd0, 16'd0, 16'hFFFF, 7'd3));
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		queue_random(N_RAND / 3 - 11);
		wait_drained();
		// hold the sender while the next batch is queued, then swap the idling
		hold_send = 1'b1;
		queue_random(N_RAND / 3);
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		send_idle_pct = 56;
		recv_idle_pct = 8;
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(N_RAND / 3);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d rays and %0d voxel items, incl. ties, boundaries, wraps",
			n_rays, n_voxels);
		$display("stalls on both sides in three idling phases; %0d mismatches", n_bad);
		if (n_bad == 0 && voxels_due.size() == 0)
			$display("voxel_ray_traversal_test: clean");
		else
			$display("voxel_ray_traversal_test: errors");
		$finish;
	end

	// slowest run: ~410 rays, each with set-up and up to 64 voxels with stalls, is far below this
	initial begin
		#20ms;
		$display("voxel_ray_traversal_test: errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/vrt_pkg.sv
src/vrt_div.sv
src/voxel_ray_traversal.sv
test/voxel_ray_traversal_test.sv
